// File: rtl/core/tcs_pkg.sv
package tcs_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Character and attribute codes
  localparam logic [7:0]  CH_NL       = 8'd10;
  localparam logic [7:0]  CH_TAB      = 8'd9;
  localparam logic [7:0]  CH_SPACE    = 8'h20;
  localparam logic [7:0]  BLANK_ATTR  = 8'h0F;
  localparam logic [7:0]  COLOR_RESET = 8'h07;
  localparam logic [15:0] RESET_CELL  = 16'h0720;
  localparam int          TAB_SPACES  = 4;

  // Request codes on the input beat
  localparam logic [3:0] REQ_PUT       = 4'd0;
  localparam logic [3:0] REQ_PUT_COLOR = 4'd1;
  localparam logic [3:0] REQ_SWAP      = 4'd2;
  localparam logic [3:0] REQ_SWAP_CLR  = 4'd3;
  localparam logic [3:0] REQ_BACKSPACE = 4'd4;
  localparam logic [3:0] REQ_UP        = 4'd5;
  localparam logic [3:0] REQ_DOWN      = 4'd6;
  localparam logic [3:0] REQ_LEFT      = 4'd7;
  localparam logic [3:0] REQ_RIGHT     = 4'd8;
  localparam logic [3:0] REQ_CLEAR     = 4'd9;
  localparam logic [3:0] REQ_SCLEAR    = 4'd10;
  localparam logic [3:0] REQ_READ      = 4'd11;

  typedef enum logic [3:0] {
    OP_NOP, OP_PUT, OP_PUTC, OP_SWAP, OP_SWAPC, OP_BS, OP_UP, OP_DOWN,
    OP_LEFT, OP_RIGHT, OP_CLR, OP_SCLR, OP_READ
  } op_t;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [7:0]  char_code;
    logic [7:0]  attr_color;
    logic [10:0] cell_index;
  } req_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [10:0] cursor_reg;
    logic [15:0] cell_data;
    logic [10:0] up_history_cells;
    logic [10:0] down_history_cells;
  } rsp_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  char_code;
    logic [7:0]  attr_color;
    logic [10:0] cell_index;
  } cmd_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_STEP, S_SYNC, S_SD_PUSH, S_SD_SHIFT, S_SD_FILL,
    S_SU_PUSH, S_SU_SHIFT, S_SU_FILL, S_CLEAR, S_RDWAIT, S_FIN, S_OUT
  } state_t;

endpackage

// File: rtl/core/tcs_front.sv
module tcs_front import tcs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic q_valid,
  input  logic q_ready,
  output cmd_t q_cmd
);

  cmd_t       slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] fill;
  cmd_t       dec;
  logic       push;
  logic       pop;

  // Classify the request code
  always_comb begin
    dec.char_code  = req.char_code;
    dec.attr_color = req.attr_color;
    dec.cell_index = req.cell_index;
    case (req.req_type)
      REQ_PUT:       dec.op = OP_PUT;
      REQ_PUT_COLOR: dec.op = OP_PUTC;
      REQ_SWAP:      dec.op = OP_SWAP;
      REQ_SWAP_CLR:  dec.op = OP_SWAPC;
      REQ_BACKSPACE: dec.op = OP_BS;
      REQ_UP:        dec.op = OP_UP;
      REQ_DOWN:      dec.op = OP_DOWN;
      REQ_LEFT:      dec.op = OP_LEFT;
      REQ_RIGHT:     dec.op = OP_RIGHT;
      REQ_CLEAR:     dec.op = OP_CLR;
      REQ_SCLEAR:    dec.op = OP_SCLR;
      REQ_READ:      dec.op = OP_READ;
      default:       dec.op = OP_NOP;
    endcase
  end

  assign req_ready = (fill != 2'd2);
  assign q_valid   = (fill != 2'd0);
  assign q_cmd     = slot[rd_ptr];
  assign push      = req_valid && req_ready;
  assign pop       = q_valid && q_ready;

  // Two-entry queue between front and back
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: rtl/core/tcs_back.sv
module tcs_back import tcs_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       q_valid,
  output logic       q_ready,
  input  cmd_t       q_cmd,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output rsp_t       rsp
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int REP_W  = $clog2(ROWS + TAB_SPACES + 1);
  localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

  logic [15:0] scr_mem [CELLS];
  logic [15:0] up_mem  [CELLS];
  logic [15:0] dn_mem  [CELLS];

  state_t             state, state_next;
  logic [CNT_W-1:0]   ptr, ptr_next;
  logic               phase, phase_next;
  logic [ROW_W-1:0]   row, row_next;
  logic [COL_W-1:0]   col, col_next;
  logic [ADDR_W-1:0]  hw, hw_next;
  logic [CNT_W-1:0]   up_cnt, up_cnt_next;
  logic [CNT_W-1:0]   dn_cnt, dn_cnt_next;
  logic [REP_W-1:0]   rep, rep_next;
  cmd_t               cmd, cmd_next;
  logic [15:0]        data, data_next;
  logic [7:0]         text_color;
  rsp_t               rsp_next;
  logic               rsp_load;

  logic               scr_we, up_we, dn_we;
  logic [ADDR_W-1:0]  scr_waddr, scr_raddr, up_waddr, up_raddr, dn_waddr, dn_raddr;
  logic [15:0]        scr_wdata, up_wdata, dn_wdata;
  logic [15:0]        scr_rdata, up_rdata, dn_rdata;

  logic [ADDR_W-1:0]  pos;
  logic [ADDR_W-1:0]  ptr_a;
  logic               last_row, last_col, first_col;
  logic               step_nl, step_scroll;
  logic               idx_ok;
  logic [7:0]         put_attr, put_char;
  logic [CNT_W-1:0]   up_push_idx, dn_push_idx;
  logic               out_free;

  assign ptr_a     = ptr[ADDR_W-1:0];
  assign pos       = ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS)) + ADDR_W'(col);
  assign last_row  = (row == ROW_W'(ROWS - 1));
  assign last_col  = (col == COL_W'(COLUMNS - 1));
  assign first_col = (col == '0);
  assign step_nl   = (cmd.op == OP_SCLR) || (cmd.char_code == CH_NL);
  assign step_scroll = last_row && (step_nl || last_col);
  assign idx_ok    = (32'(q_cmd.cell_index) < 32'(CELLS));
  assign put_attr  = (cmd.op == OP_PUTC) ? cmd.attr_color : text_color;
  assign put_char  = (cmd.char_code == CH_TAB) ? CH_SPACE : cmd.char_code;
  // A full stack restarts at zero before the push
  assign up_push_idx = (up_cnt >= CNT_W'(CELLS)) ? '0 : up_cnt;
  assign dn_push_idx = (dn_cnt >= CNT_W'(CELLS)) ? '0 : dn_cnt;
  assign out_free  = !rsp_valid || rsp_ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT:
        if (ptr == CNT_W'(CELLS - 1)) state_next = S_IDLE;
      S_IDLE:
        if (q_valid) begin
          case (q_cmd.op)
            OP_PUT, OP_PUTC, OP_SCLR: state_next = S_STEP;
            OP_BS, OP_LEFT, OP_RIGHT: state_next = S_SYNC;
            OP_UP:
              if (row == '0 && up_cnt != '0) state_next = S_SU_PUSH;
              else                             state_next = S_SYNC;
            OP_DOWN:
              if (last_row && dn_cnt != '0) state_next = S_SD_PUSH;
              else                            state_next = S_SYNC;
            OP_CLR:  state_next = S_CLEAR;
            OP_READ: state_next = idx_ok ? S_RDWAIT : S_FIN;
            default: state_next = S_FIN;
          endcase
        end
      S_STEP:
        state_next = step_scroll ? S_SD_PUSH : S_SYNC;
      S_SYNC:
        state_next = (rep <= REP_W'(1)) ? S_FIN : S_STEP;
      S_SD_PUSH:
        if (phase && ptr == CNT_W'(COLUMNS - 1)) state_next = S_SD_SHIFT;
      S_SD_SHIFT:
        if (phase && ptr == CNT_W'(LAST_ROW_BASE - 1)) state_next = S_SD_FILL;
      S_SD_FILL:
        if ((phase || dn_cnt == '0) && ptr == '0) state_next = S_SYNC;
      S_SU_PUSH:
        if (phase && ptr == CNT_W'(COLUMNS - 1)) state_next = S_SU_SHIFT;
      S_SU_SHIFT:
        if (phase && ptr == CNT_W'(COLUMNS)) state_next = S_SU_FILL;
      S_SU_FILL:
        if ((phase || up_cnt == '0) && ptr == '0) state_next = S_SYNC;
      S_CLEAR:
        if (ptr == CNT_W'(CELLS - 1)) state_next = S_FIN;
      S_RDWAIT: state_next = S_FIN;
      S_FIN:    state_next = S_OUT;
      S_OUT:
        if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Datapath and memory ports
  always_comb begin
    ptr_next    = ptr;
    phase_next  = phase;
    row_next    = row;
    col_next    = col;
    hw_next     = hw;
    up_cnt_next = up_cnt;
    dn_cnt_next = dn_cnt;
    rep_next    = rep;
    cmd_next    = cmd;
    data_next   = data;
    q_ready     = 1'b0;
    rsp_load    = 1'b0;
    scr_we = 1'b0; scr_waddr = pos; scr_wdata = RESET_CELL; scr_raddr = ptr_a;
    up_we  = 1'b0; up_waddr = up_push_idx[ADDR_W-1:0]; up_wdata = scr_rdata;
    up_raddr = ADDR_W'(up_cnt - CNT_W'(1));
    dn_we  = 1'b0; dn_waddr = dn_push_idx[ADDR_W-1:0]; dn_wdata = scr_rdata;
    dn_raddr = ADDR_W'(dn_cnt - CNT_W'(1));
    rsp_next = rsp;

    case (state)
      // Fill the screen with its reset cell after reset
      S_INIT: begin
        scr_we    = 1'b1;
        scr_waddr = ptr_a;
        scr_wdata = RESET_CELL;
        ptr_next  = (ptr == CNT_W'(CELLS - 1)) ? '0 : ptr + CNT_W'(1);
      end

      // Take the next command and start it
      S_IDLE:
        if (q_valid) begin
          q_ready    = 1'b1;
          cmd_next   = q_cmd;
          data_next  = '0;
          rep_next   = REP_W'(1);
          ptr_next   = '0;
          phase_next = 1'b0;
          case (q_cmd.op)
            OP_PUT, OP_PUTC:
              if (q_cmd.char_code == CH_TAB) rep_next = REP_W'(TAB_SPACES);
            OP_SCLR: rep_next = REP_W'(ROWS);
            OP_SWAP, OP_SWAPC: begin
              scr_we    = 1'b1;
              scr_wdata = {(q_cmd.op == OP_SWAPC) ? q_cmd.attr_color : text_color,
                           q_cmd.char_code};
            end
            OP_BS:
              if (!first_col) begin
                col_next  = col - COL_W'(1);
                scr_we    = 1'b1;
                scr_waddr = pos - ADDR_W'(1);
                scr_wdata = {text_color, CH_SPACE};
              end
            OP_UP:
              if (row != '0) row_next = row - ROW_W'(1);
            OP_DOWN:
              if (!last_row) row_next = row + ROW_W'(1);
            OP_LEFT:
              if (!first_col) col_next = col - COL_W'(1);
            OP_RIGHT:
              if (!last_col) col_next = col + COL_W'(1);
            OP_READ:
              scr_raddr = ADDR_W'(q_cmd.cell_index);
            default: ;
          endcase
        end

      // One character or newline of a print
      S_STEP: begin
        ptr_next   = '0;
        phase_next = 1'b0;
        if (step_nl) begin
          col_next = '0;
          if (!last_row) row_next = row + ROW_W'(1);
        end else begin
          scr_we    = 1'b1;
          scr_wdata = {put_attr, put_char};
          if (last_col) begin
            col_next = '0;
            if (!last_row) row_next = row + ROW_W'(1);
          end else begin
            col_next = col + COL_W'(1);
          end
        end
      end

      // Copy the cursor to the hardware cursor, count down repeats
      S_SYNC: begin
        hw_next = pos;
        if (rep > REP_W'(1)) rep_next = rep - REP_W'(1);
      end

      // Scroll down: push top row onto the upward stack
      S_SD_PUSH:
        if (!phase) begin
          scr_raddr  = ptr_a;
          phase_next = 1'b1;
        end else begin
          up_we       = 1'b1;
          up_cnt_next = up_push_idx + CNT_W'(1);
          phase_next  = 1'b0;
          ptr_next    = (ptr == CNT_W'(COLUMNS - 1)) ? '0 : ptr + CNT_W'(1);
        end

      // Scroll down: move every row up by one
      S_SD_SHIFT:
        if (!phase) begin
          scr_raddr  = ptr_a + ADDR_W'(COLUMNS);
          phase_next = 1'b1;
        end else begin
          scr_we     = 1'b1;
          scr_waddr  = ptr_a;
          scr_wdata  = scr_rdata;
          phase_next = 1'b0;
          ptr_next   = (ptr == CNT_W'(LAST_ROW_BASE - 1)) ?
                       CNT_W'(COLUMNS - 1) : ptr + CNT_W'(1);
        end

      // Scroll down: refill bottom row from the downward stack, last cell first, blank once it is empty
      S_SD_FILL: begin
        scr_waddr = ptr_a + ADDR_W'(LAST_ROW_BASE);
        if (!phase && dn_cnt != '0) begin
          dn_cnt_next = dn_cnt - CNT_W'(1);
          phase_next  = 1'b1;
        end else begin
          scr_we     = 1'b1;
          scr_wdata  = phase ? dn_rdata : {BLANK_ATTR, CH_SPACE};
          phase_next = 1'b0;
          if (ptr == '0) begin
            row_next = ROW_W'(ROWS - 1);
            col_next = '0;
          end else begin
            ptr_next = ptr - CNT_W'(1);
          end
        end
      end

      // Scroll up: push bottom row onto the downward stack
      S_SU_PUSH:
        if (!phase) begin
          scr_raddr  = ptr_a + ADDR_W'(LAST_ROW_BASE);
          phase_next = 1'b1;
        end else begin
          dn_we       = 1'b1;
          dn_cnt_next = dn_push_idx + CNT_W'(1);
          phase_next  = 1'b0;
          ptr_next    = (ptr == CNT_W'(COLUMNS - 1)) ?
                        CNT_W'(CELLS - 1) : ptr + CNT_W'(1);
        end

      // Scroll up: move every row down by one, bottom first
      S_SU_SHIFT:
        if (!phase) begin
          scr_raddr  = ptr_a - ADDR_W'(COLUMNS);
          phase_next = 1'b1;
        end else begin
          scr_we     = 1'b1;
          scr_waddr  = ptr_a;
          scr_wdata  = scr_rdata;
          phase_next = 1'b0;
          ptr_next   = (ptr == CNT_W'(COLUMNS)) ? CNT_W'(COLUMNS - 1) : ptr - CNT_W'(1);
        end

      // Scroll up: refill top row from the upward stack, last cell first, blank once it is empty
      S_SU_FILL: begin
        scr_waddr = ptr_a;
        if (!phase && up_cnt != '0) begin
          up_cnt_next = up_cnt - CNT_W'(1);
          phase_next  = 1'b1;
        end else begin
          scr_we     = 1'b1;
          scr_wdata  = phase ? up_rdata : {BLANK_ATTR, CH_SPACE};
          phase_next = 1'b0;
          if (ptr == '0) begin
            row_next = '0;
            col_next = '0;
          end else begin
            ptr_next = ptr - CNT_W'(1);
          end
        end
      end

      // Blank the screen in the current attribute, home the cursor and empty both stacks
      S_CLEAR: begin
        scr_we    = 1'b1;
        scr_waddr = ptr_a;
        scr_wdata = {text_color, CH_SPACE};
        ptr_next  = ptr + CNT_W'(1);
        if (ptr == CNT_W'(CELLS - 1)) begin
          row_next    = '0;
          col_next    = '0;
          up_cnt_next = '0;
          dn_cnt_next = '0;
        end
      end

      S_RDWAIT: data_next = scr_rdata;

      // Home the cursor after a scroll clear
      S_FIN:
        if (cmd.op == OP_SCLR) begin
          row_next = '0;
          col_next = '0;
        end

      // Hand the result to the output register
      S_OUT:
        if (out_free) begin
          rsp_load                    = 1'b1;
          rsp_next.cursor_row         = 5'(row);
          rsp_next.cursor_col         = 7'(col);
          rsp_next.cursor_reg         = 11'(hw);
          rsp_next.cell_data          = data;
          rsp_next.up_history_cells   = 11'(up_cnt);
          rsp_next.down_history_cells = 11'(dn_cnt);
        end

      default: ;
    endcase
  end

  // Memories
  always_ff @(posedge clk) begin
    if (scr_we) scr_mem[scr_waddr] <= scr_wdata;
    scr_rdata <= scr_mem[scr_raddr];
  end

  always_ff @(posedge clk) begin
    if (up_we) up_mem[up_waddr] <= up_wdata;
    up_rdata <= up_mem[up_raddr];
  end

  always_ff @(posedge clk) begin
    if (dn_we) dn_mem[dn_waddr] <= dn_wdata;
    dn_rdata <= dn_mem[dn_raddr];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd  <= cmd_next;
    data <= data_next;
    rep  <= rep_next;
    rsp  <= rsp_next;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      ptr        <= '0;
      phase      <= 1'b0;
      row        <= '0;
      col        <= '0;
      hw         <= '0;
      up_cnt     <= '0;
      dn_cnt     <= '0;
      text_color <= COLOR_RESET;
      rsp_valid  <= 1'b0;
    end else begin
      state  <= state_next;
      ptr    <= ptr_next;
      phase  <= phase_next;
      row    <= row_next;
      col    <= col_next;
      hw     <= hw_next;
      up_cnt <= up_cnt_next;
      dn_cnt <= dn_cnt_next;
      if (cfg_we) text_color <= cfg_wdata;
      if (rsp_load)       rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  a_up_bound: assert property (@(posedge clk) disable iff (rst)
    up_cnt <= CNT_W'(CELLS)) else $error("upward stack count beyond capacity");

  a_dn_bound: assert property (@(posedge clk) disable iff (rst)
    dn_cnt <= CNT_W'(CELLS)) else $error("downward stack count beyond capacity");

  a_cursor: assert property (@(posedge clk) disable iff (rst)
    32'(row) < 32'(ROWS) && 32'(col) < 32'(COLUMNS)) else $error("cursor off screen");

  a_out_wait: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && rsp_valid && !rsp_ready |=> state == S_OUT)
    else $error("result dropped while output stalled");

endmodule

// File: rtl/core/text_console_with_scrollback_core.sv
// Text console with scrollback: one terminal command per request beat, one
// response beat per command. After reset the screen is filled with blank grey
// cells, one cell a cycle, and no command starts until the fill is done,
// though the queue takes up to two beats meanwhile. A scroll walks the screen
// memory through its single read and write port, reading each cell before it
// writes it; a clear writes every cell in turn, and a scroll clear makes up
// to ROWS scrolls. A two-beat request queue and a response register let both
// sides stall independently. text_color may be written only while the block
// is idle.
module text_console_with_scrollback_core import tcs_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  req_t       req,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output rsp_t       rsp,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  // Accept and classify commands
  tcs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd)
  );

  // Execute commands against the screen and history stacks
  tcs_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// File: verif/tcs_checker.sv
module tcs_checker import tcs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       req_ready,
  input  req_t       req,
  input  logic       rsp_valid,
  input  logic       rsp_ready,
  input  rsp_t       rsp,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  output int         errors,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS  = COLUMNS_DEF;
  localparam int LINES = ROWS_DEF;
  localparam int CELLS = COLS * LINES;

  // Shadow copy of the console
  logic [15:0] screen_m [CELLS];
  logic [15:0] up_m [CELLS];
  logic [15:0] dn_m [CELLS];
  int          up_n, dn_n, row, col, hwc;
  logic [7:0]  color;
  rsp_t        expected_q [$];

  initial errors = 0;
  assign pending = expected_q.size();

  function automatic logic [15:0] blank_cell();
    return {BLANK_ATTR, CH_SPACE};
  endfunction

  function void push_up(logic [15:0] v);
    if (up_n >= CELLS) up_n = 0;
    up_m[up_n] = v;
    up_n++;
  endfunction

  function void push_dn(logic [15:0] v);
    if (dn_n >= CELLS) dn_n = 0;
    dn_m[dn_n] = v;
    dn_n++;
  endfunction

  function logic [15:0] pop_up();
    if (up_n == 0) return blank_cell();
    up_n--;
    return up_m[up_n];
  endfunction

  function logic [15:0] pop_dn();
    if (dn_n == 0) return blank_cell();
    dn_n--;
    return dn_m[dn_n];
  endfunction

  function void sync_hw();
    hwc = row * COLS + col;
  endfunction

  // Move the screen one row up, top row into the upward stack
  function void scroll_fwd();
    for (int x = 0; x < COLS; x++) push_up(screen_m[x]);
    for (int y = 0; y + 1 < LINES; y++)
      for (int x = 0; x < COLS; x++) screen_m[y*COLS+x] = screen_m[(y+1)*COLS+x];
    if (dn_n == 0) begin
      for (int x = 0; x < COLS; x++) screen_m[(LINES-1)*COLS+x] = blank_cell();
    end else begin
      for (int x = COLS - 1; x >= 0; x--) screen_m[(LINES-1)*COLS+x] = pop_dn();
    end
    row = LINES - 1;
    col = 0;
  endfunction

  // Move the screen one row down, bottom row into the downward stack
  function void scroll_back();
    if (up_n == 0) return;
    for (int x = 0; x < COLS; x++) push_dn(screen_m[(LINES-1)*COLS+x]);
    for (int y = LINES - 1; y > 0; y--)
      for (int x = 0; x < COLS; x++) screen_m[y*COLS+x] = screen_m[(y-1)*COLS+x];
    for (int x = 1; x <= COLS; x++) screen_m[COLS-x] = pop_up();
    row = 0;
    col = 0;
  endfunction

  function void emit(logic [7:0] ch, logic [7:0] a);
    screen_m[row*COLS+col] = {a, ch};
    col++;
    if (col == COLS) begin
      col = 0;
      row++;
      if (row == LINES) scroll_fwd();
    end
    sync_hw();
  endfunction

  function void print_char(logic [7:0] ch, logic [7:0] a);
    if (ch == CH_NL) begin
      row++;
      if (row == LINES) scroll_fwd();
      col = 0;
      sync_hw();
    end else if (ch == CH_TAB) begin
      for (int i = 0; i < TAB_SPACES; i++) emit(CH_SPACE, a);
    end else begin
      emit(ch, a);
    end
  endfunction

  // Apply one command and build the response it should give
  function rsp_t console_step(req_t r);
    rsp_t        o;
    logic [15:0] data;
    data = '0;
    case (r.req_type)
      REQ_PUT:       print_char(r.char_code, color);
      REQ_PUT_COLOR: print_char(r.char_code, r.attr_color);
      REQ_SWAP:      screen_m[row*COLS+col] = {color, r.char_code};
      REQ_SWAP_CLR:  screen_m[row*COLS+col] = {r.attr_color, r.char_code};
      REQ_BACKSPACE: begin
        if (col != 0) begin
          col--;
          screen_m[row*COLS+col] = {color, CH_SPACE};
        end
        sync_hw();
      end
      REQ_UP: begin
        if (row == 0) begin
          scroll_back();
          row = 0;
        end else begin
          row--;
        end
        sync_hw();
      end
      REQ_DOWN: begin
        if (row + 1 > LINES - 1) begin
          if (dn_n > 0) scroll_fwd();
          row = LINES - 1;
        end else begin
          row++;
        end
        sync_hw();
      end
      REQ_LEFT: begin
        if (col != 0) col--;
        sync_hw();
      end
      REQ_RIGHT: begin
        if (col + 1 > COLS - 1) col = COLS - 1;
        else col++;
        sync_hw();
      end
      REQ_CLEAR: begin
        row = 0;
        col = 0;
        for (int i = 0; i < CELLS; i++) screen_m[i] = {color, CH_SPACE};
        up_n = 0;
        dn_n = 0;
      end
      REQ_SCLEAR: begin
        for (int i = 0; i < LINES; i++) print_char(CH_NL, color);
        row = 0;
        col = 0;
      end
      REQ_READ: begin
        if (r.cell_index < CELLS) data = screen_m[r.cell_index];
      end
      default: ;
    endcase
    o.cursor_row         = row[4:0];
    o.cursor_col         = col[6:0];
    o.cursor_reg         = hwc[10:0];
    o.cell_data          = data;
    o.up_history_cells   = up_n[10:0];
    o.down_history_cells = dn_n[10:0];
    return o;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Sample on the falling edge ahead of the edge at which each beat is taken
  always @(negedge clk) begin
    rsp_t e;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) screen_m[i] = RESET_CELL;
      up_n = 0;
      dn_n = 0;
      row = 0;
      col = 0;
      hwc = 0;
      color = COLOR_RESET;
      expected_q.delete();
    end else begin
      if (cfg_we) color = cfg_wdata;
      if (req_valid && req_ready) expected_q.push_back(console_step(req));
      if (rsp_valid && rsp_ready) begin
        if (expected_q.size() == 0) begin
          $error("response beat with nothing expected");
          errors++;
        end else begin
          e = expected_q.pop_front();
          check_field("cursor_row", e.cursor_row, rsp.cursor_row);
          check_field("cursor_col", e.cursor_col, rsp.cursor_col);
          check_field("cursor_reg", e.cursor_reg, rsp.cursor_reg);
          check_field("cell_data", e.cell_data, rsp.cell_data);
          check_field("up_history_cells", e.up_history_cells, rsp.up_history_cells);
          check_field("down_history_cells", e.down_history_cells,
                      rsp.down_history_cells);
        end
      end
    end
  end

endmodule

// File: verif/testbench.sv
module testbench;
  import tcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 400000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_ready;
  req_t       req = '0;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  rsp_t       rsp;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  int errors, pending;
  int sent = 0;
  int idle_cycles = 0;
  bit tx_steady = 0;
  bit rx_steady = 0;
  bit hold_req = 0;

  text_console_with_scrollback_core dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  tcs_checker scoreboard (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: random back-pressure, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      rsp_ready <= 1'b0;
      repeat (300) @(posedge clk);
      hold_req = 0;
    end else begin
      rsp_ready <= rx_steady ? 1'b1 : ($urandom_range(99) >= 33);
    end
  end

  // Abort when no beat moves for too long
  always @(negedge clk) begin
    if (!rst) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offer one command beat and hold it until taken
  task automatic issue(input logic [3:0] kind, input logic [7:0] ch,
                       input logic [7:0] attr, input logic [10:0] idx);
    bit rdy;
    if (!tx_steady && $urandom_range(99) < 33) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 33);
    end
    req <= '{req_type: kind, char_code: ch, attr_color: attr, cell_index: idx};
    req_valid <= 1'b1;
    forever begin
      @(negedge clk);
      rdy = req_ready;
      @(posedge clk);
      if (rdy) break;
    end
    sent++;
  endtask

  task automatic issue_op(input logic [3:0] kind);
    issue(kind, 8'($urandom_range(255)), 8'($urandom_range(255)),
          11'($urandom_range(2047)));
  endtask

  // Drain every outstanding response, then let the block settle
  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_color(input logic [7:0] v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Weighted random command, cheap ones dominating; scrolls kept rare
  task automatic random_cmd();
    int         pick;
    logic [7:0] ch;
    pick = $urandom_range(999);
    ch = 8'($urandom_range(255));
    if ($urandom_range(99) < 4) ch = CH_NL;
    else if ($urandom_range(99) < 5) ch = CH_TAB;
    if (pick < 300)      issue(REQ_PUT, ch, 8'($urandom_range(255)),
                               11'($urandom_range(2047)));
    else if (pick < 420) issue(REQ_PUT_COLOR, ch, 8'($urandom_range(255)),
                               11'($urandom_range(2047)));
    else if (pick < 480) issue_op(REQ_SWAP);
    else if (pick < 540) issue_op(REQ_SWAP_CLR);
    else if (pick < 620) issue_op(REQ_BACKSPACE);
    else if (pick < 660) issue_op(REQ_UP);
    else if (pick < 700) issue_op(REQ_DOWN);
    else if (pick < 780) issue_op(REQ_LEFT);
    else if (pick < 860) issue_op(REQ_RIGHT);
    else if (pick < 867) issue_op(REQ_CLEAR);
    else if (pick < 868) issue_op(REQ_SCLEAR);
    else if (pick < 970) issue_op(REQ_READ);
    else                 issue_op(4'(12 + $urandom_range(3)));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: reads of fresh cells, edges of every field, unused codes
    issue(REQ_READ, 8'h00, 8'h00, 11'd0);
    issue(REQ_READ, 8'hFF, 8'hFF, 11'd1999);
    issue(REQ_READ, 8'h00, 8'h00, 11'd2000);
    issue(REQ_READ, 8'hFF, 8'hFF, 11'd2047);
    issue(4'd12, 8'h00, 8'h00, 11'd0);
    issue(4'd15, 8'hFF, 8'hFF, 11'd2047);
    issue(REQ_LEFT, 8'h00, 8'h00, 11'd0);
    issue(REQ_BACKSPACE, 8'h00, 8'h00, 11'd0);
    issue(REQ_UP, 8'h00, 8'h00, 11'd0);
    issue(REQ_PUT, 8'h41, 8'h00, 11'd0);
    issue(REQ_PUT_COLOR, 8'hFF, 8'hFF, 11'd0);
    issue(REQ_PUT_COLOR, 8'h00, 8'h00, 11'd0);
    issue(REQ_PUT, CH_TAB, 8'h00, 11'd0);
    issue(REQ_SWAP, 8'h5A, 8'h00, 11'd0);
    issue(REQ_SWAP_CLR, 8'hFF, 8'hFF, 11'd0);
    issue(REQ_BACKSPACE, 8'h00, 8'h00, 11'd0);
    issue(REQ_READ, 8'h00, 8'h00, 11'd0);
    issue(REQ_PUT_COLOR, CH_NL, 8'h00, 11'd0);
    for (int i = 0; i < 80; i++) issue(REQ_RIGHT, 8'h00, 8'h00, 11'd0);
    // Walk to the bottom, scroll in a blank row, then fill and wrap the stack
    for (int i = 0; i < 24; i++) issue(REQ_DOWN, 8'h00, 8'h00, 11'd0);
    issue(REQ_PUT, CH_NL, 8'h00, 11'd0);
    issue(REQ_READ, 8'h00, 8'h00, 11'd1999);
    for (int i = 0; i < 24; i++) issue(REQ_DOWN, 8'h00, 8'h00, 11'd0);
    issue(REQ_SCLEAR, 8'h00, 8'h00, 11'd0);
    issue(REQ_UP, 8'h00, 8'h00, 11'd0);
    for (int i = 0; i < 24; i++) issue(REQ_DOWN, 8'h00, 8'h00, 11'd0);
    issue(REQ_DOWN, 8'h00, 8'h00, 11'd0);
    issue(REQ_READ, 8'h00, 8'h00, 11'd1920);
    issue(REQ_CLEAR, 8'h00, 8'h00, 11'd0);
    issue(REQ_READ, 8'h00, 8'h00, 11'd5);
    drain();

    // Random phases under different colours and flow-control patterns
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_color(8'h00);
        1: set_color(8'hFF);
        default: set_color(8'($urandom_range(255)));
      endcase
      tx_steady = (phase == 1);
      rx_steady = (phase == 1);
      if (phase == 2) hold_req = 1;
      for (int n = 0; n < 218; n++) random_cmd();
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Ran %0d console commands: all request codes, field extremes, scrolling,",
             sent);
    $display("stack wrap, out-of-range reads, four colours and a long receiver hold-off.");
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// File: text_console_with_scrollback_core.f
rtl/core/tcs_pkg.sv
rtl/core/tcs_front.sv
rtl/core/tcs_back.sv
rtl/core/text_console_with_scrollback_core.sv
verif/tcs_checker.sv
verif/testbench.sv
